>>> rtl/rrfr_pkg.sv
// Package for the reader response frame receiver.
// Holds the byte role and frame status codes and the start byte values.
// It has no dependencies.
`default_nettype none

package rrfr_pkg;

  typedef enum logic [2:0] {
    ROLE_NONE     = 3'd0,
    ROLE_START    = 3'd1,
    ROLE_LEN_HIGH = 3'd2,
    ROLE_LEN_LOW  = 3'd3,
    ROLE_STATUS   = 3'd4,
    ROLE_PAYLOAD  = 3'd5,
    ROLE_CHECK    = 3'd6
  } byte_role_t;

  typedef enum logic [2:0] {
    FRAME_BUSY      = 3'd0,
    FRAME_OK        = 3'd1,
    FRAME_CHECK_ERR = 3'd2,
    FRAME_ERROR     = 3'd3,
    FRAME_TIMEOUT   = 3'd4
  } frame_status_t;

  localparam logic [7:0] START_NORMAL = 8'h60;
  localparam logic [7:0] START_ERROR  = 8'hE0;
  localparam logic [7:0] LIMIT_RESET  = 8'd50;

endpackage

`default_nettype wire

>>> rtl/reader_response_frame_receiver.sv
// Top level of the reader response frame receiver.
// Depends on rrfr_pkg for role and status codes and start byte values.
`default_nettype none

// Takes one poll per request on the slave side: tuser high means the poll
// found no byte, otherwise tdata carries the received byte. Every poll gives
// exactly one result on the master side, in the cycle after it is accepted,
// and a new poll can be taken in every cycle: the frame state and the
// result register update in the same clock, and the slave side stays ready
// while the result register is empty or being emptied. A result carries
// the echoed frame byte, its role and the frame status; a nonzero status
// closes the frame (ok, check mismatch, error frame or timeout). The idle
// poll limit is written through the cfg channel, which is always ready.
module reader_response_frame_receiver
  import rrfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
  input  wire logic       s_tuser,   // [0] operation
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] byte_out
  output logic [5:0]      m_tuser,   // [2:0] byte_role, [5:3] frame_status
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data   // [7:0] idle_poll_limit
);

  typedef enum logic [2:0] {
    PH_HUNT     = 3'd0,
    PH_LEN_HIGH = 3'd1,
    PH_LEN_LOW  = 3'd2,
    PH_STATUS   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_CHECK    = 3'd5
  } phase_t;

  phase_t        phase, phase_next;
  logic [15:0]   bytes_remaining, bytes_remaining_next;
  logic [7:0]    running_xor, running_xor_next;
  logic [7:0]    length_high, length_high_next;
  logic [7:0]    empty_poll_count, empty_poll_count_next;
  logic          error_frame_flag, error_frame_flag_next;
  logic          zero_length_flag, zero_length_flag_next;
  logic [7:0]    idle_poll_limit;

  logic          accept;
  logic [7:0]    echo;
  byte_role_t    role;
  frame_status_t status;
  logic [8:0]    poll_count_inc;
  logic [15:0]   length_full;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign poll_count_inc = {1'b0, empty_poll_count} + 9'd1;
  assign length_full    = {length_high, s_tdata};

  always_comb begin
    phase_next            = phase;
    bytes_remaining_next  = bytes_remaining;
    running_xor_next      = running_xor;
    length_high_next      = length_high;
    empty_poll_count_next = empty_poll_count;
    error_frame_flag_next = error_frame_flag;
    zero_length_flag_next = zero_length_flag;
    echo   = 8'd0;
    role   = ROLE_NONE;
    status = FRAME_BUSY;

    if (s_tuser) begin
      // A limit of zero also times out on the first empty poll.
      if (poll_count_inc >= {1'b0, idle_poll_limit}) begin
        status                = FRAME_TIMEOUT;
        empty_poll_count_next = 8'd0;
        phase_next            = PH_HUNT;
      end else begin
        empty_poll_count_next = poll_count_inc[7:0];
      end
    end else begin
      empty_poll_count_next = 8'd0;
      case (phase)
        PH_LEN_HIGH: begin
          echo             = s_tdata;
          role             = ROLE_LEN_HIGH;
          length_high_next = s_tdata;
          running_xor_next = running_xor ^ s_tdata;
          phase_next       = PH_LEN_LOW;
        end
        PH_LEN_LOW: begin
          echo                  = s_tdata;
          role                  = ROLE_LEN_LOW;
          running_xor_next      = running_xor ^ s_tdata;
          bytes_remaining_next  = length_full;
          zero_length_flag_next = (length_full == 16'd0);
          phase_next            = PH_STATUS;
        end
        PH_STATUS: begin
          echo             = s_tdata;
          role             = ROLE_STATUS;
          running_xor_next = running_xor ^ s_tdata;
          phase_next       = (bytes_remaining == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          echo                 = s_tdata;
          role                 = ROLE_PAYLOAD;
          running_xor_next     = running_xor ^ s_tdata;
          bytes_remaining_next = bytes_remaining - 16'd1;
          if (bytes_remaining == 16'd1) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          echo = s_tdata;
          role = ROLE_CHECK;
          if (error_frame_flag) begin
            status = FRAME_ERROR;
          end else if (zero_length_flag) begin
            status = FRAME_OK;
          end else begin
            status = (running_xor == s_tdata) ? FRAME_OK : FRAME_CHECK_ERR;
          end
          phase_next = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
          if (s_tdata == START_NORMAL || s_tdata == START_ERROR) begin
            echo                  = s_tdata;
            role                  = ROLE_START;
            running_xor_next      = s_tdata;
            error_frame_flag_next = (s_tdata == START_ERROR);
            zero_length_flag_next = 1'b0;
            bytes_remaining_next  = 16'd0;
            length_high_next      = 8'd0;
            phase_next            = PH_LEN_HIGH;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HUNT;
      bytes_remaining  <= 16'd0;
      running_xor      <= 8'd0;
      length_high      <= 8'd0;
      empty_poll_count <= 8'd0;
      error_frame_flag <= 1'b0;
      zero_length_flag <= 1'b0;
      idle_poll_limit  <= LIMIT_RESET;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        idle_poll_limit <= cfg_data;
      end
      if (accept) begin
        phase            <= phase_next;
        bytes_remaining  <= bytes_remaining_next;
        running_xor      <= running_xor_next;
        length_high      <= length_high_next;
        empty_poll_count <= empty_poll_count_next;
        error_frame_flag <= error_frame_flag_next;
        zero_length_flag <= zero_length_flag_next;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by m_tvalid.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= echo;
      m_tuser <= {status, role};
    end
  end

endmodule

`default_nettype wire

>>> bench/reader_response_frame_receiver_test.sv
// Testbench for the reader response frame receiver: drives polls and bytes on the
// stream input, predicts every result and checks it field by field on the output.
// Depends on rrfr_pkg and the reader_response_frame_receiver top level.
`default_nettype none

module reader_response_frame_receiver_test;
  import rrfr_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int N_SETTINGS   = 8;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN_HIGH, PH_LEN_LOW, PH_STATUS, PH_PAYLOAD, PH_CHECK
  } rx_phase_t;

  typedef enum logic [1:0] {JOB_POLL, JOB_CONFIG, JOB_DRAIN} job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       no_byte;
    logic [7:0] value;
  } job_t;

  typedef struct packed {
    logic [7:0]    echo;
    byte_role_t    role;
    frame_status_t status;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;
  wire  [5:0] m_tuser;
  wire        cfg_ready;

  reader_response_frame_receiver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver state as the checker sees it.
  rx_phase_t   rx_phase;
  logic [16:0] payload_left;
  logic [7:0]  xor_acc;
  logic [7:0]  len_msb;
  logic [7:0]  empty_run;
  logic        err_frame;
  logic        zero_len;
  logic [7:0]  poll_limit;

  job_t   job_q[$];
  reply_t reply_q[$];

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   settle = 0;
  int   stall_cycles = 0;
  int   polls_taken = 0;
  int   results_seen = 0;
  int   limit_writes = 0;
  int   fails = 0;
  int   n_ok = 0, n_mismatch = 0, n_err_frame = 0, n_timeout = 0;

  // Stimulus generator state.
  int unsigned gen_limit;
  int unsigned gen_items = 0;
  int unsigned poll_pct = 0;

  function automatic reply_t next_reply(logic no_byte, logic [7:0] b);
    reply_t     r;
    logic [8:0] bumped;
    r = '{echo: 8'h00, role: ROLE_NONE, status: FRAME_BUSY};
    if (no_byte) begin
      bumped = {1'b0, empty_run} + 9'd1;
      if (bumped >= {1'b0, poll_limit}) begin
        r.status = FRAME_TIMEOUT;
        empty_run = 8'd0;
        rx_phase = PH_HUNT;
      end else begin
        empty_run = bumped[7:0];
      end
    end else begin
      empty_run = 8'd0;
      case (rx_phase)
        PH_LEN_HIGH: begin
          r.echo = b;
          r.role = ROLE_LEN_HIGH;
          len_msb = b;
          xor_acc ^= b;
          rx_phase = PH_LEN_LOW;
        end
        PH_LEN_LOW: begin
          r.echo = b;
          r.role = ROLE_LEN_LOW;
          xor_acc ^= b;
          payload_left = {1'b0, len_msb, b};
          zero_len = ({len_msb, b} == 16'd0);
          rx_phase = PH_STATUS;
        end
        PH_STATUS: begin
          r.echo = b;
          r.role = ROLE_STATUS;
          xor_acc ^= b;
          rx_phase = (payload_left == 17'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          r.echo = b;
          r.role = ROLE_PAYLOAD;
          xor_acc ^= b;
          payload_left = payload_left - 17'd1;
          if (payload_left == 17'd0) rx_phase = PH_CHECK;
        end
        PH_CHECK: begin
          r.echo = b;
          r.role = ROLE_CHECK;
          if (err_frame) r.status = FRAME_ERROR;
          else if (zero_len) r.status = FRAME_OK;
          else r.status = (xor_acc == b) ? FRAME_OK : FRAME_CHECK_ERR;
          rx_phase = PH_HUNT;
        end
        default: begin
          rx_phase = PH_HUNT;
          if (b == START_NORMAL || b == START_ERROR) begin
            r.echo = b;
            r.role = ROLE_START;
            xor_acc = b;
            err_frame = (b == START_ERROR);
            zero_len = 1'b0;
            payload_left = 17'd0;
            len_msb = 8'd0;
            rx_phase = PH_LEN_HIGH;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic add_job(job_kind_t kind, logic [7:0] value);
    job_q.push_back('{kind: kind, no_byte: 1'b0, value: value});
  endtask

  // An empty poll carries a random byte that the block must ignore.
  task automatic add_poll();
    job_q.push_back('{kind: JOB_POLL, no_byte: 1'b1, value: 8'($urandom_range(255))});
    gen_items++;
  endtask

  task automatic add_polls(int unsigned n);
    repeat (n) add_poll();
  endtask

  // A lone empty poll may slip in before a byte when it cannot time out by itself.
  task automatic add_byte(logic [7:0] b);
    if (gen_limit >= 2 && $urandom_range(99) < poll_pct) add_poll();
    job_q.push_back('{kind: JOB_POLL, no_byte: 1'b0, value: b});
    gen_items++;
  endtask

  task automatic add_frame(logic [7:0] first, int unsigned len, logic spoil);
    logic [7:0]  acc;
    logic [7:0]  v;
    int unsigned i;
    acc = first;
    add_byte(first);
    v = len[15:8];
    acc ^= v;
    add_byte(v);
    v = len[7:0];
    acc ^= v;
    add_byte(v);
    v = 8'($urandom_range(255));
    acc ^= v;
    add_byte(v);
    for (i = 0; i < len; i++) begin
      v = 8'($urandom_range(255));
      acc ^= v;
      add_byte(v);
    end
    add_byte(spoil ? acc ^ 8'($urandom_range(1, 255)) : acc);
  endtask

  // Driver: inputs change on the falling edge, each signal assigned once per step.
  always @(negedge clk) begin
    logic       nv;
    logic       nc;
    logic       calm;
    logic       no_byte_n;
    logic [7:0] byte_n;
    logic [7:0] cfg_n;
    job_t       head;
    calm = (polls_taken >= 500 && polls_taken < 700);
    nv = s_tvalid && !in_taken;
    nc = cfg_valid && !cfg_taken;
    no_byte_n = s_tuser;
    byte_n = s_tdata;
    cfg_n = cfg_data;
    if (reply_q.size() == 0 && !nv) settle++;
    else settle = 0;
    if (!rst && !nv && !nc && job_q.size() != 0) begin
      head = job_q[0];
      if (head.kind == JOB_POLL) begin
        if (calm || $urandom_range(99) >= 7) begin
          head = job_q.pop_front();
          nv = 1'b1;
          no_byte_n = head.no_byte;
          byte_n = head.value;
        end
      end else if (settle >= 3) begin
        // Register writes and pauses wait until every pending result is out.
        head = job_q.pop_front();
        settle = 0;
        if (head.kind == JOB_CONFIG) begin
          nc = 1'b1;
          cfg_n = head.value;
        end
      end
    end
    s_tvalid <= nv;
    s_tuser <= no_byte_n;
    s_tdata <= byte_n;
    cfg_valid <= nc;
    cfg_data <= cfg_n;
    m_tready <= calm || ($urandom_range(99) >= 7);
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      in_taken = 1'b0;
      cfg_taken = 1'b0;
      rx_phase = PH_HUNT;
      payload_left = 17'd0;
      xor_acc = 8'd0;
      len_msb = 8'd0;
      empty_run = 8'd0;
      err_frame = 1'b0;
      zero_len = 1'b0;
      poll_limit = LIMIT_RESET;
    end else begin
      in_taken = s_tvalid && s_tready;
      cfg_taken = cfg_valid && cfg_ready;
      if (cfg_taken) begin
        poll_limit = cfg_data;
        limit_writes++;
      end
      if (in_taken) begin
        reply_q.push_back(next_reply(s_tuser, s_tdata));
        polls_taken++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          $error("result arrived with no request pending");
          fails++;
        end else begin
          want = reply_q.pop_front();
          if (m_tdata !== want.echo) begin
            $error("byte_out: expected %02h, got %02h", want.echo, m_tdata);
            fails++;
          end
          if (m_tuser[2:0] !== want.role) begin
            $error("byte_role: expected %0d, got %0d", want.role, m_tuser[2:0]);
            fails++;
          end
          if (m_tuser[5:3] !== want.status) begin
            $error("frame_status: expected %0d, got %0d", want.status, m_tuser[5:3]);
            fails++;
          end
          case (want.status)
            FRAME_OK:        n_ok++;
            FRAME_CHECK_ERR: n_mismatch++;
            FRAME_ERROR:     n_err_frame++;
            FRAME_TIMEOUT:   n_timeout++;
            default: ;
          endcase
        end
      end
      if (in_taken || cfg_taken || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[reader_response_frame_receiver] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned lim;
    int unsigned phase_end;
    int unsigned pick;
    gen_limit = LIMIT_RESET;
    poll_pct = 0;

    // Directed part under the reset limit.
    add_byte(8'hFF);
    add_frame(START_ERROR, 0, 1'b1);
    add_frame(START_NORMAL, 1, 1'b0);
    add_frame(START_NORMAL, 0, 1'b1);
    add_frame(START_NORMAL, 1, 1'b1);
    add_poll();
    add_job(JOB_CONFIG, 8'd1);
    gen_limit = 1;
    add_poll();
    add_job(JOB_CONFIG, 8'd0);
    gen_limit = 0;
    add_poll();
    // Largest length, cut short by a timeout.
    add_job(JOB_CONFIG, 8'd3);
    gen_limit = 3;
    add_byte(START_NORMAL);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'h5A);
    add_byte(8'hA5);
    add_polls(3);

    // Random part, one stretch per limit setting.
    for (int s = 0; s < N_SETTINGS; s++) begin
      case (s)
        0: lim = 255;
        1: lim = 1;
        2: lim = $urandom_range(2, 6);
        3: lim = 0;
        4: lim = LIMIT_RESET;
        5: lim = $urandom_range(1, 255);
        6: lim = $urandom_range(7, 20);
        default: lim = $urandom_range(2, 4);
      endcase
      phase_end = RANDOM_ITEMS * (s + 1) / N_SETTINGS;
      add_job(JOB_CONFIG, 8'(lim));
      gen_limit = lim;
      poll_pct = 4;
      if (s == 0) begin
        // One poll short of the limit, then a full run.
        add_polls(254);
        add_byte(8'($urandom_range(255)));
        add_polls(255);
      end
      if (s == 4) add_frame(START_NORMAL, 256, 1'($urandom_range(1)));
      // Every stretch still gets some random traffic after a long directed run.
      if (phase_end < gen_items + 40) phase_end = gen_items + 40;
      while (gen_items < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          add_frame(($urandom_range(4) == 0) ? START_ERROR : START_NORMAL,
                    ($urandom_range(29) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6),
                    ($urandom_range(6) == 0));
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
        end else if (pick < 90) begin
          // Broken frame: a start and a few bytes, then silence.
          add_byte(($urandom_range(1) == 0) ? START_ERROR : START_NORMAL);
          repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(255)));
          add_polls((gen_limit <= 20) ? gen_limit : $urandom_range(1, 5));
        end else begin
          add_polls($urandom_range(1, (gen_limit < 8) ? gen_limit + 1 : 8));
        end
        if (pick == 50) add_job(JOB_DRAIN, 8'd0);
      end
    end

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    while (job_q.size() != 0 || s_tvalid || cfg_valid || reply_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Checked %0d results from %0d requests over %0d limit writes.",
             results_seen, polls_taken, limit_writes);
    $display("Frames closed: %0d ok, %0d check mismatch, %0d error frame, %0d timeout.",
             n_ok, n_mismatch, n_err_frame, n_timeout);
    if (fails == 0) begin
      $display("[reader_response_frame_receiver] OK");
    end else begin
      $display("[reader_response_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
